[rtl/core/ancs_pkg.sv]
// ancs_pkg: shared types and constants for the ant next-city selector
// opcode, rule, register index and state encodings; no dependencies
`timescale 1ns / 1ps

package ancs_pkg;

   localparam int DEF_MAX_CITIES     = 1024;
   localparam int DEF_MAX_NEIGHBOURS = 32;
   localparam int DEF_VALUE_BITS     = 32;

   // fixed field widths of the request and response channels
   localparam int CITY_PORT_BITS  = 10;
   localparam int CFG_CITY_BITS   = 11;
   localparam int CFG_NBR_BITS    = 6;
   localparam int CFG_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int FRACTION_BITS   = 16;
   localparam int EPOCH_BITS      = 8;

   // reset values of the configuration registers
   localparam logic [CFG_CITY_BITS-1:0] RESET_CITY_COUNT     = 11'd1024;
   localparam logic [CFG_NBR_BITS-1:0]  RESET_NEIGHBOUR_COUNT = 6'd20;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CITY_COUNT      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEIGHBOUR_COUNT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BEST_THRESHOLD  = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE_VALUE     = 2'd0,
      OP_WRITE_NEIGHBOUR = 2'd1,
      OP_PLACE_ANT       = 2'd2,
      OP_STEP            = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      RULE_ROULETTE       = 2'd0,
      RULE_BEST_CANDIDATE = 2'd1,
      RULE_BEST_OVERALL   = 2'd2,
      RULE_PLACED_START   = 2'd3
   } rule_type;

   typedef enum logic [1:0] {
      SCAN_GREEDY,
      SCAN_SUM,
      SCAN_WALK,
      SCAN_GLOBAL
   } scan_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MOD,
      ST_PLACE,
      ST_SCAN,
      ST_MUL,
      ST_EMIT
   } state_type;

endpackage

[rtl/core/ant_next_city_selector.sv]
// ant_next_city_selector: next-city choice for one ant (pseudo-random proportional rule)
// depends on ancs_pkg; holds the value, neighbour and visited-epoch memories
`timescale 1ns / 1ps

// One ant's tour is built here, one request at a time. Write requests load the
// attractiveness table (unsigned 16.16) and the candidate lists and do not leave
// the idle state. A place request reduces the start city modulo the city count
// with a bit-serial remainder and returns the start city. A step request walks the
// candidate list through a three-stage read pipeline (neighbour memory, then
// visited and value memories), one candidate per cycle: a greedy step makes one
// pass over the list, a roulette step a sum pass, a multiply and a walk pass,
// and a walk that runs off the end adds a greedy pass. When no candidate is free
// the fallback scans every city. The visited map is kept as epoch tags so that
// a place request does not have to clear it; after reset, and when the epoch
// reaches all ones at a place request, a clearing pass over every tag runs
// during which no request is taken. Configuration writes are taken at any
// time and must only be issued while the block is idle. The response sits in
// an output register, so a new request is taken while a response still waits.
module ant_next_city_selector #(
   parameter int MAX_CITIES     = ancs_pkg::DEF_MAX_CITIES,
   parameter int MAX_NEIGHBOURS = ancs_pkg::DEF_MAX_NEIGHBOURS,
   parameter int VALUE_BITS     = ancs_pkg::DEF_VALUE_BITS
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [9:0]  req_row_city,
   input  logic [9:0]  req_column_index,
   input  logic [31:0] req_entry_value,
   input  logic [15:0] req_random_choice,
   input  logic [15:0] req_random_wheel,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_chosen_city,
   output logic [9:0]  rsp_tour_position,
   output logic [1:0]  rsp_rule_used,
   output logic        rsp_tour_done
);

   // address and counter widths
   localparam int CB = $clog2(MAX_CITIES);                             // city address
   localparam int NB = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1; // list position
   localparam int CW = (CB > ancs_pkg::CITY_PORT_BITS) ? CB : ancs_pkg::CITY_PORT_BITS;
   localparam int NW = CB + 1;                                          // holds MAX_CITIES
   localparam int KW = NB + 1;                                          // holds MAX_NEIGHBOURS
   localparam int SW = (NW > KW) ? NW : KW;                             // scan index
   localparam int TW = VALUE_BITS + KW;                                 // wheel total
   localparam int EW = ancs_pkg::EPOCH_BITS;
   localparam int FB = ancs_pkg::FRACTION_BITS;
   localparam int PB = ancs_pkg::CITY_PORT_BITS;

   // ---------------------------------------------------------------- memories
   logic [VALUE_BITS-1:0] attr_mem [2**(2*CB)];
   logic [PB-1:0]         nb_mem   [2**(CB+NB)];
   logic [EW-1:0]         vis_mem  [2**CB];

   logic                  attr_we;
   logic [2*CB-1:0]       attr_wa, attr_ra;
   logic [VALUE_BITS-1:0] attr_q;
   logic                  nb_we;
   logic [CB+NB-1:0]      nb_wa, nb_ra;
   logic [PB-1:0]         nb_q;
   logic                  vis_we;
   logic [CB-1:0]         vis_wa, vis_ra;
   logic [EW-1:0]         vis_wd, vis_q;

   // ---------------------------------------------------------------- registers
   ancs_pkg::state_type   state_ff, state_in;
   ancs_pkg::scan_type    kind_ff, kind_in;
   ancs_pkg::rule_type    rule_ff, rule_in;

   logic [ancs_pkg::CFG_CITY_BITS-1:0] city_count_ff;
   logic [ancs_pkg::CFG_NBR_BITS-1:0]  nbr_count_ff;
   logic [ancs_pkg::CFG_DATA_BITS-1:0] threshold_ff;

   logic [CB-1:0]   sweep_idx_ff, sweep_idx_in;
   logic            place_pend_ff, place_pend_in;
   logic [EW-1:0]   epoch_ff, epoch_in;
   logic [CW-1:0]   cur_ff, cur_in;
   logic [NW-1:0]   step_ff, step_in;
   logic            active_ff, active_in;
   logic [PB-1:0]   row_ff, row_in;
   logic [FB-1:0]   rwheel_ff, rwheel_in;
   logic [NW-1:0]   rem_ff, rem_in;
   logic [3:0]      mod_cnt_ff, mod_cnt_in;

   // scan pipeline
   logic            issue_ff, issue_in;
   logic [SW-1:0]   idx_ff, idx_in;
   logic [SW-1:0]   len_ff, len_in;
   logic            s1_v_ff, s1_v_in;
   logic [SW-1:0]   s1_idx_ff, s1_idx_in;
   logic            s2_v_ff, s2_v_in;
   logic [CW-1:0]   s2_city_ff, s2_city_in;
   logic            s2_inr_ff, s2_inr_in;

   // accumulators
   logic            have_ff, have_in;
   logic [CW-1:0]   best_city_ff, best_city_in;
   logic [VALUE_BITS-1:0] best_val_ff, best_val_in;
   logic [TW-1:0]   total_ff, total_in;
   logic [TW-1:0]   partial_ff, partial_in;
   logic [TW-1:0]   target_ff, target_in;
   logic            found_ff, found_in;

   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [PB-1:0]   rsp_city_ff, rsp_city_in;
   logic [PB-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [1:0]      rsp_rule_ff, rsp_rule_in;
   logic            rsp_done_ff, rsp_done_in;

   // ---------------------------------------------------------------- helpers
   logic              req_accept;
   logic              out_free;
   logic              engine_idle;
   logic [NW-1:0]     n_eff;
   logic [KW-1:0]     k_eff;
   logic              step_over;
   logic              greedy;
   logic [CW-1:0]     city1;
   logic              inr1;
   logic              usable;
   logic [TW-1:0]     slot_val;
   logic [TW-1:0]     partial_sum;
   logic [NW:0]       rem_shift;
   logic [TW+FB-1:0]  product;
   logic              scan_start;
   ancs_pkg::scan_type scan_kind;

   assign req_accept  = req_valid && !req_stall;
   assign req_stall   = (state_ff != ancs_pkg::ST_IDLE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign engine_idle = !issue_ff && !s1_v_ff && !s2_v_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_city   = rsp_city_ff;
   assign rsp_tour_position = rsp_pos_ff;
   assign rsp_rule_used     = rsp_rule_ff;
   assign rsp_tour_done     = rsp_done_ff;

   // effective city and neighbour counts, clamped to their legal ranges
   always_comb begin
      if (city_count_ff < 2) begin
         n_eff = NW'(2);
      end else if (32'(city_count_ff) > MAX_CITIES) begin
         n_eff = NW'(MAX_CITIES);
      end else begin
         n_eff = NW'(city_count_ff);
      end
      if (nbr_count_ff == '0) begin
         k_eff = KW'(1);
      end else if (32'(nbr_count_ff) > MAX_NEIGHBOURS) begin
         k_eff = KW'(MAX_NEIGHBOURS);
      end else begin
         k_eff = KW'(nbr_count_ff);
      end
   end

   assign step_over = (step_ff >= n_eff);
   assign greedy    = (threshold_ff != '0) && (req_random_choice < threshold_ff);

   // stage 1: candidate city from the list, or the scan index itself when global
   assign city1 = (kind_ff == ancs_pkg::SCAN_GLOBAL) ? CW'(s1_idx_ff) : CW'(nb_q);
   assign inr1  = ({1'b0, city1} < (CW+1)'(n_eff));

   // stage 2: a city counts when it is in range and not tagged with this epoch
   assign usable      = s2_v_ff && s2_inr_ff && (vis_q != epoch_ff);
   assign slot_val    = usable ? TW'(attr_q) : '0;
   assign partial_sum = partial_ff + slot_val;

   assign rem_shift = {rem_ff, row_ff[4'(PB-1) - mod_cnt_ff]};
   assign product   = (TW+FB)'(total_ff) * (TW+FB)'(rwheel_ff);

   // memory addresses and write ports
   always_comb begin
      attr_we = req_accept && (req_opcode == ancs_pkg::OP_WRITE_VALUE)
                && (32'(req_row_city) < MAX_CITIES) && (32'(req_column_index) < MAX_CITIES);
      attr_wa = {CB'(req_row_city), CB'(req_column_index)};
      nb_we   = req_accept && (req_opcode == ancs_pkg::OP_WRITE_NEIGHBOUR)
                && (32'(req_row_city) < MAX_CITIES)
                && (32'(req_column_index) < MAX_NEIGHBOURS);
      nb_wa   = {CB'(req_row_city), NB'(req_column_index)};
      nb_ra   = {CB'(cur_ff), NB'(idx_ff)};
      attr_ra = {CB'(cur_ff), CB'(city1)};
      vis_ra  = CB'(city1);

      vis_we = 1'b0;
      vis_wa = sweep_idx_ff;
      vis_wd = '0;
      case (state_ff)
         ancs_pkg::ST_SWEEP: begin
            vis_we = 1'b1;
         end
         ancs_pkg::ST_PLACE: begin
            vis_we = (epoch_ff != '1) && out_free;
            vis_wa = CB'(rem_ff);
            vis_wd = epoch_ff + EW'(1);
         end
         ancs_pkg::ST_EMIT: begin
            vis_we = out_free;
            vis_wa = CB'(best_city_ff);
            vis_wd = epoch_ff;
         end
         default: begin
            vis_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (attr_we) begin
         attr_mem[attr_wa] <= VALUE_BITS'(req_entry_value);
      end
      attr_q <= attr_mem[attr_ra];
   end

   always_ff @(posedge clock) begin
      if (nb_we) begin
         nb_mem[nb_wa] <= req_entry_value[PB-1:0];
      end
      nb_q <= nb_mem[nb_ra];
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_wa] <= vis_wd;
      end
      vis_q <= vis_mem[vis_ra];
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ancs_pkg::ST_SWEEP: begin
            if (sweep_idx_ff == '1) begin
               state_in = place_pend_ff ? ancs_pkg::ST_PLACE : ancs_pkg::ST_IDLE;
            end
         end
         ancs_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (ancs_pkg::opcode_type'(req_opcode))
                  ancs_pkg::OP_PLACE_ANT: state_in = ancs_pkg::ST_MOD;
                  ancs_pkg::OP_STEP: begin
                     if (active_ff && !step_over) begin
                        state_in = ancs_pkg::ST_SCAN;
                     end
                  end
                  default: state_in = ancs_pkg::ST_IDLE;
               endcase
            end
         end
         ancs_pkg::ST_MOD: begin
            if (mod_cnt_ff == 4'(PB-1)) begin
               state_in = ancs_pkg::ST_PLACE;
            end
         end
         ancs_pkg::ST_PLACE: begin
            if (epoch_ff == '1) begin
               state_in = ancs_pkg::ST_SWEEP;
            end else if (out_free) begin
               state_in = ancs_pkg::ST_IDLE;
            end
         end
         ancs_pkg::ST_SCAN: begin
            if (engine_idle) begin
               unique case (kind_ff)
                  ancs_pkg::SCAN_GREEDY:
                     state_in = have_ff ? ancs_pkg::ST_EMIT : ancs_pkg::ST_SCAN;
                  ancs_pkg::SCAN_SUM:
                     state_in = (total_ff == '0) ? ancs_pkg::ST_SCAN : ancs_pkg::ST_MUL;
                  ancs_pkg::SCAN_WALK:
                     state_in = found_ff ? ancs_pkg::ST_EMIT : ancs_pkg::ST_SCAN;
                  ancs_pkg::SCAN_GLOBAL:
                     state_in = have_ff ? ancs_pkg::ST_EMIT : ancs_pkg::ST_IDLE;
                  default: state_in = ancs_pkg::ST_IDLE;
               endcase
            end
         end
         ancs_pkg::ST_MUL: state_in = ancs_pkg::ST_SCAN;
         ancs_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = ancs_pkg::ST_IDLE;
            end
         end
         default: state_in = ancs_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      kind_in       = kind_ff;
      rule_in       = rule_ff;
      sweep_idx_in  = sweep_idx_ff;
      place_pend_in = place_pend_ff;
      epoch_in      = epoch_ff;
      cur_in        = cur_ff;
      step_in       = step_ff;
      active_in     = active_ff;
      row_in        = row_ff;
      rwheel_in     = rwheel_ff;
      rem_in        = rem_ff;
      mod_cnt_in    = mod_cnt_ff;
      len_in        = len_ff;
      have_in       = have_ff;
      best_city_in  = best_city_ff;
      best_val_in   = best_val_ff;
      total_in      = total_ff;
      partial_in    = partial_ff;
      target_in     = target_ff;
      found_in      = found_ff;
      rsp_city_in   = rsp_city_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_rule_in   = rsp_rule_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      scan_start    = 1'b0;
      scan_kind     = kind_ff;

      // stage 0: issue one list position or city per cycle
      issue_in  = issue_ff;
      idx_in    = idx_ff;
      s1_v_in   = issue_ff;
      s1_idx_in = idx_ff;
      if (issue_ff) begin
         idx_in = idx_ff + SW'(1);
         if (idx_ff + SW'(1) == len_ff) begin
            issue_in = 1'b0;
         end
      end
      // stage 1 to stage 2
      s2_v_in    = s1_v_ff;
      s2_city_in = city1;
      s2_inr_in  = inr1;

      // stage 2: evaluate
      if (s2_v_ff) begin
         case (kind_ff)
            ancs_pkg::SCAN_SUM: begin
               total_in = total_ff + slot_val;
            end
            ancs_pkg::SCAN_WALK: begin
               if (!found_ff) begin
                  partial_in = partial_sum;
                  if (partial_sum > target_ff) begin
                     found_in     = 1'b1;
                     best_city_in = s2_city_ff;
                  end
               end
            end
            default: begin
               // strictly greater wins, so ties keep the earliest entry
               if (usable && (!have_ff || attr_q > best_val_ff)) begin
                  have_in      = 1'b1;
                  best_city_in = s2_city_ff;
                  best_val_in  = attr_q;
               end
            end
         endcase
      end

      case (state_ff)
         ancs_pkg::ST_SWEEP: begin
            sweep_idx_in = sweep_idx_ff + CB'(1);
            if (sweep_idx_ff == '1) begin
               epoch_in      = EW'(1);
               place_pend_in = 1'b0;
            end
         end
         ancs_pkg::ST_IDLE: begin
            if (req_accept) begin
               row_in     = req_row_city;
               rwheel_in  = req_random_wheel;
               rem_in     = '0;
               mod_cnt_in = '0;
               if (req_opcode == ancs_pkg::OP_STEP && active_ff) begin
                  if (step_over) begin
                     active_in = 1'b0;
                  end else begin
                     scan_start = 1'b1;
                     scan_kind  = greedy ? ancs_pkg::SCAN_GREEDY : ancs_pkg::SCAN_SUM;
                  end
               end
            end
         end
         ancs_pkg::ST_MOD: begin
            // restoring remainder, one bit of the start city per cycle
            if (rem_shift >= {1'b0, n_eff}) begin
               rem_in = NW'(rem_shift - {1'b0, n_eff});
            end else begin
               rem_in = NW'(rem_shift);
            end
            mod_cnt_in = mod_cnt_ff + 4'd1;
         end
         ancs_pkg::ST_PLACE: begin
            if (epoch_ff == '1) begin
               // epoch wrap: clear the tags first, then place again
               sweep_idx_in  = '0;
               place_pend_in = 1'b1;
            end else if (out_free) begin
               epoch_in     = epoch_ff + EW'(1);
               cur_in       = CW'(rem_ff);
               step_in      = NW'(1);
               active_in    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_city_in  = PB'(rem_ff);
               rsp_pos_in   = '0;
               rsp_rule_in  = ancs_pkg::RULE_PLACED_START;
               rsp_done_in  = 1'b0;
            end
         end
         ancs_pkg::ST_SCAN: begin
            if (engine_idle) begin
               case (kind_ff)
                  ancs_pkg::SCAN_GREEDY: begin
                     if (have_ff) begin
                        rule_in = ancs_pkg::RULE_BEST_CANDIDATE;
                     end else begin
                        scan_start = 1'b1;
                        scan_kind  = ancs_pkg::SCAN_GLOBAL;
                     end
                  end
                  ancs_pkg::SCAN_SUM: begin
                     if (total_ff == '0) begin
                        scan_start = 1'b1;
                        scan_kind  = ancs_pkg::SCAN_GLOBAL;
                     end
                  end
                  ancs_pkg::SCAN_WALK: begin
                     if (found_ff) begin
                        rule_in = ancs_pkg::RULE_ROULETTE;
                     end else begin
                        // wheel ran off the end: best candidate instead
                        scan_start = 1'b1;
                        scan_kind  = ancs_pkg::SCAN_GREEDY;
                     end
                  end
                  default: begin
                     if (have_ff) begin
                        rule_in = ancs_pkg::RULE_BEST_OVERALL;
                     end else begin
                        active_in = 1'b0;
                     end
                  end
               endcase
            end
         end
         ancs_pkg::ST_MUL: begin
            // target = floor(total * random_wheel / 65536)
            target_in  = TW'(product >> FB);
            scan_start = 1'b1;
            scan_kind  = ancs_pkg::SCAN_WALK;
         end
         ancs_pkg::ST_EMIT: begin
            if (out_free) begin
               cur_in       = best_city_ff;
               step_in      = step_ff + NW'(1);
               rsp_valid_in = 1'b1;
               rsp_city_in  = PB'(best_city_ff);
               rsp_pos_in   = PB'(step_ff);
               rsp_rule_in  = rule_ff;
               rsp_done_in  = ({1'b0, step_ff} + (NW+1)'(1) >= {1'b0, n_eff});
               if ({1'b0, step_ff} + (NW+1)'(1) >= {1'b0, n_eff}) begin
                  active_in = 1'b0;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase

      if (scan_start) begin
         kind_in    = scan_kind;
         issue_in   = 1'b1;
         idx_in     = '0;
         len_in     = (scan_kind == ancs_pkg::SCAN_GLOBAL) ? SW'(n_eff) : SW'(k_eff);
         have_in    = 1'b0;
         total_in   = '0;
         partial_in = '0;
         found_in   = 1'b0;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ancs_pkg::ST_SWEEP;
         sweep_idx_ff  <= '0;
         place_pend_ff <= 1'b0;
         epoch_ff      <= '0;
         cur_ff        <= '0;
         step_ff       <= '0;
         active_ff     <= 1'b0;
         issue_ff      <= 1'b0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         city_count_ff <= ancs_pkg::RESET_CITY_COUNT;
         nbr_count_ff  <= ancs_pkg::RESET_NEIGHBOUR_COUNT;
         threshold_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_idx_ff  <= sweep_idx_in;
         place_pend_ff <= place_pend_in;
         epoch_ff      <= epoch_in;
         cur_ff        <= cur_in;
         step_ff       <= step_in;
         active_ff     <= active_in;
         issue_ff      <= issue_in;
         s1_v_ff       <= s1_v_in;
         s2_v_ff       <= s2_v_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               ancs_pkg::CSR_CITY_COUNT:
                  city_count_ff <= csr_write_data[ancs_pkg::CFG_CITY_BITS-1:0];
               ancs_pkg::CSR_NEIGHBOUR_COUNT:
                  nbr_count_ff <= csr_write_data[ancs_pkg::CFG_NBR_BITS-1:0];
               ancs_pkg::CSR_BEST_THRESHOLD:
                  threshold_ff <= csr_write_data;
               default: threshold_ff <= threshold_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      rule_ff      <= rule_in;
      row_ff       <= row_in;
      rwheel_ff    <= rwheel_in;
      rem_ff       <= rem_in;
      mod_cnt_ff   <= mod_cnt_in;
      idx_ff       <= idx_in;
      len_ff       <= len_in;
      s1_idx_ff    <= s1_idx_in;
      s2_city_ff   <= s2_city_in;
      s2_inr_ff    <= s2_inr_in;
      have_ff      <= have_in;
      best_city_ff <= best_city_in;
      best_val_ff  <= best_val_in;
      total_ff     <= total_in;
      partial_ff   <= partial_in;
      target_ff    <= target_in;
      found_ff     <= found_in;
      rsp_city_ff  <= rsp_city_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_rule_ff  <= rsp_rule_in;
      rsp_done_ff  <= rsp_done_in;
   end

endmodule

[verif/tb_ant_next_city_selector.sv]
// tb_ant_next_city_selector: self-checking bench for the ant next-city selector
// drives directed and random requests, predicts each chosen city, compares responses
// depends on ancs_pkg and ant_next_city_selector
`timescale 1ns / 1ps

module tb_ant_next_city_selector;
   import ancs_pkg::*;

   // cities whose value rows and candidate lists are fully loaded; tours stay inside
   localparam int WORLD_CITIES = 24;
   localparam int SETTLE_CYCLES = 1200;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      opcode_type  op;
      logic [9:0]  row;
      logic [9:0]  col;
      logic [31:0] val;
      logic [15:0] rchoice;
      logic [15:0] rwheel;
   } request_t;

   typedef struct {
      logic [9:0] city;
      logic [9:0] position;
      rule_type   rule;
      logic       done;
   } choice_t;

   typedef enum {DIR_REQUEST, DIR_CSR, DIR_LOAD_WORLD} dir_kind_t;

   typedef struct {
      dir_kind_t                 kind;
      request_t                  req;
      logic [CSR_INDEX_BITS-1:0] csr_idx;
      logic [15:0]               csr_data;
      bit                        typed;
      choice_t                   choice;
   } dir_row_t;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [9:0]  req_row_city;
   logic [9:0]  req_column_index;
   logic [31:0] req_entry_value;
   logic [15:0] req_random_choice;
   logic [15:0] req_random_wheel;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [9:0]  rsp_chosen_city;
   logic [9:0]  rsp_tour_position;
   logic [1:0]  rsp_rule_used;
   logic        rsp_tour_done;

   ant_next_city_selector i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_row_city      (req_row_city),
      .req_column_index  (req_column_index),
      .req_entry_value   (req_entry_value),
      .req_random_choice (req_random_choice),
      .req_random_wheel  (req_random_wheel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_chosen_city   (rsp_chosen_city),
      .rsp_tour_position (rsp_tour_position),
      .rsp_rule_used     (rsp_rule_used),
      .rsp_tour_done     (rsp_tour_done)
   );

   // predictor state: own copy of tables, ant and registers
   bit [31:0] attr_mem [int];
   bit [9:0]  nbr_mem [1024][32];
   bit        visited [1024];
   bit [31:0] wheel_slot [32];
   int        cur_city;
   int        step_no;
   bit        ant_live;
   bit [10:0] reg_cities;
   bit [5:0]  reg_nbrs;
   bit [15:0] reg_threshold;

   choice_t   expected_choices [$];
   int        mismatch_count;
   int        sender_gap;
   int        receiver_gap;
   longint    cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < receiver_gap);
   end

   function automatic bit [31:0] attr_at(input int from, input int to);
      int key;
      key = from * 1024 + to;
      return attr_mem.exists(key) ? attr_mem[key] : 32'd0;
   endfunction

   function automatic int live_cities();
      int n;
      n = reg_cities;
      if (n < 2) n = 2;
      if (n > DEF_MAX_CITIES) n = DEF_MAX_CITIES;
      return n;
   endfunction

   function automatic int live_nbrs();
      int k;
      k = reg_nbrs;
      if (k < 1) k = 1;
      if (k > DEF_MAX_NEIGHBOURS) k = DEF_MAX_NEIGHBOURS;
      return k;
   endfunction

   // candidate at list slot i, or -1 when beyond the city count or already visited
   function automatic int free_candidate(input int i, input int n);
      int c;
      c = nbr_mem[cur_city][i];
      if (c >= n || visited[c]) return -1;
      return c;
   endfunction

   // earliest strictly-greater wins, zero values still qualify
   function automatic int best_free_candidate(input int n, input int k);
      int best;
      int c;
      bit [31:0] bv;
      best = -1;
      bv = '0;
      for (int i = 0; i < k; i++) begin
         c = free_candidate(i, n);
         if (c >= 0 && (best < 0 || attr_at(cur_city, c) > bv)) begin
            best = c;
            bv = attr_at(cur_city, c);
         end
      end
      return best;
   endfunction

   function automatic int best_free_city(input int n);
      int best;
      bit [31:0] bv;
      best = -1;
      bv = '0;
      for (int c = 0; c < n; c++) begin
         if (!visited[c] && (best < 0 || attr_at(cur_city, c) > bv)) begin
            best = c;
            bv = attr_at(cur_city, c);
         end
      end
      return best;
   endfunction

   // updates the predicted state for one request; returns 1 when a response follows
   function automatic bit predict_next_city(input request_t q, output choice_t r);
      int n;
      int k;
      int nxt;
      int i;
      int start;
      rule_type rule;
      bit [63:0] total;
      bit [63:0] target;
      bit [63:0] running;
      n = live_cities();
      k = live_nbrs();
      nxt = -1;
      rule = RULE_ROULETTE;
      r = '{default: '0, rule: RULE_ROULETTE};
      case (q.op)
         OP_WRITE_VALUE: begin
            attr_mem[int'(q.row) * 1024 + int'(q.col)] = q.val;
            return 1'b0;
         end
         OP_WRITE_NEIGHBOUR: begin
            // list positions beyond the longest list are dropped
            if (q.col < DEF_MAX_NEIGHBOURS) nbr_mem[q.row][q.col] = q.val[9:0];
            return 1'b0;
         end
         OP_PLACE_ANT: begin
            start = int'(q.row) % n;
            foreach (visited[c]) visited[c] = 1'b0;
            visited[start] = 1'b1;
            cur_city = start;
            step_no = 1;
            ant_live = 1'b1;
            r = '{city: start, position: '0, rule: RULE_PLACED_START, done: 1'b0};
            return 1'b1;
         end
         default: ;
      endcase
      if (!ant_live) return 1'b0;
      if (step_no >= n) begin
         ant_live = 1'b0;
         return 1'b0;
      end
      if (reg_threshold != 0 && q.rchoice < reg_threshold) begin
         nxt = best_free_candidate(n, k);
         rule = RULE_BEST_CANDIDATE;
      end else begin
         total = '0;
         for (i = 0; i < k; i++) begin
            wheel_slot[i] = (free_candidate(i, n) >= 0) ?
                            attr_at(cur_city, free_candidate(i, n)) : 32'd0;
            total += wheel_slot[i];
         end
         if (total == 0) begin
            rule = RULE_BEST_OVERALL;
         end else begin
            // exact floor(total * wheel / 65536)
            target = (total >> 16) * q.rwheel + (((total & 64'hFFFF) * q.rwheel) >> 16);
            running = wheel_slot[0];
            i = 0;
            while (running <= target) begin
               i++;
               if (i >= k) break;
               running += wheel_slot[i];
            end
            if (i >= k) begin
               nxt = best_free_candidate(n, k);
               rule = RULE_BEST_CANDIDATE;
            end else begin
               nxt = free_candidate(i, n);
               rule = RULE_ROULETTE;
            end
         end
      end
      // no free candidate: best unvisited city of the whole row
      if (nxt < 0) begin
         nxt = best_free_city(n);
         rule = RULE_BEST_OVERALL;
      end
      if (nxt < 0) begin
         ant_live = 1'b0;
         return 1'b0;
      end
      r.city = nxt;
      r.position = step_no;
      r.rule = rule;
      visited[nxt] = 1'b1;
      cur_city = nxt;
      step_no++;
      r.done = (step_no >= n);
      if (r.done) ant_live = 1'b0;
      return 1'b1;
   endfunction

   // response checker: oldest expectation against each accepted response
   always @(posedge clock) begin
      choice_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_choices.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: city %0d pos %0d rule %0d done %0d",
                        rsp_chosen_city, rsp_tour_position, rsp_rule_used, rsp_tour_done);
         end else begin
            want = expected_choices.pop_front();
            if (rsp_chosen_city !== want.city || rsp_tour_position !== want.position ||
                rsp_rule_used !== want.rule || rsp_tour_done !== want.done) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: exp city %0d pos %0d rule %0d done %0d, got %0d %0d %0d %0d",
                           want.city, want.position, want.rule, want.done, rsp_chosen_city,
                           rsp_tour_position, rsp_rule_used, rsp_tour_done);
            end
         end
      end
   end

   // random request with every field filled; callers override what matters
   function automatic request_t random_request(input opcode_type op);
      request_t q;
      q.op = op;
      q.row = $urandom_range(1023);
      q.col = $urandom_range(1023);
      q.val = $urandom;
      q.rchoice = $urandom_range(65535);
      q.rwheel = $urandom_range(65535);
      return q;
   endfunction

   // sender: entered and left on a falling edge; valid stays high into the next call
   task automatic issue_request(input request_t q, input bit typed, input choice_t typed_choice);
      choice_t pred;
      bit got;
      while ($urandom_range(99) < sender_gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_opcode <= q.op;
      req_row_city <= q.row;
      req_column_index <= q.col;
      req_entry_value <= q.val;
      req_random_choice <= q.rchoice;
      req_random_wheel <= q.rwheel;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = predict_next_city(q, pred);
      if (got) expected_choices.push_back(typed ? typed_choice : pred);
      @(negedge clock);
   endtask

   task automatic send(input request_t q);
      choice_t none;
      none = '{default: '0, rule: RULE_ROULETTE};
      issue_request(q, 1'b0, none);
   endtask

   // wait for every response, then let a possible silent step finish
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_choices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // register writes only ever happen with the block idle
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [15:0] data);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx == CSR_CITY_COUNT) reg_cities = data[10:0];
      else if (idx == CSR_NEIGHBOUR_COUNT) reg_nbrs = data[5:0];
      else if (idx == CSR_BEST_THRESHOLD) reg_threshold = data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // fill value rows and candidate lists of the world cities; about one value in five is zero
   task automatic load_world();
      request_t q;
      for (int r = 0; r < WORLD_CITIES; r++) begin
         for (int c = 0; c < WORLD_CITIES; c++) begin
            q = random_request(OP_WRITE_VALUE);
            q.row = r;
            q.col = c;
            if ($urandom_range(4) == 0) q.val = '0;
            send(q);
         end
         for (int s = 0; s < DEF_MAX_NEIGHBOURS; s++) begin
            q = random_request(OP_WRITE_NEIGHBOUR);
            q.row = r;
            q.col = s;
            // mostly nearby cities, some beyond the city count
            q.val = {$urandom_range(4194303), 10'd0} |
                    ($urandom_range(7) == 0 ? $urandom_range(1023) : $urandom_range(31));
            send(q);
         end
      end
   endtask

   function automatic dir_row_t plan_req(input opcode_type op, input int row, input int col,
                                         input logic [31:0] val, input int rc, input int rw);
      dir_row_t d;
      d.kind = DIR_REQUEST;
      d.req = '{op: op, row: row, col: col, val: val, rchoice: rc, rwheel: rw};
      d.csr_idx = CSR_CITY_COUNT;
      d.csr_data = '0;
      d.typed = 1'b0;
      d.choice = '{default: '0, rule: RULE_ROULETTE};
      return d;
   endfunction

   function automatic dir_row_t plan_place(input int row, input int exp_city);
      dir_row_t d;
      d = plan_req(OP_PLACE_ANT, row, 0, 32'h0, 0, 0);
      d.typed = 1'b1;
      d.choice = '{city: exp_city, position: '0, rule: RULE_PLACED_START, done: 1'b0};
      return d;
   endfunction

   function automatic dir_row_t plan_csr(input logic [CSR_INDEX_BITS-1:0] idx, input int data);
      dir_row_t d;
      d = plan_req(OP_STEP, 0, 0, 32'h0, 0, 0);
      d.kind = DIR_CSR;
      d.csr_idx = idx;
      d.csr_data = data;
      return d;
   endfunction

   initial begin
      dir_row_t plan [$];
      dir_row_t d;
      request_t q;
      int city_set [6] = '{24, 8, 24, 3, 16, 2};
      int nbr_set [6] = '{32, 5, 20, 1, 63, 32};
      int thr_set [6] = '{0, 30000, 65535, 20000, 0, 40000};
      int issued;
      int pick;
      bit paused;

      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_CITY_COUNT;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_opcode = OP_WRITE_VALUE;
      req_row_city = '0;
      req_column_index = '0;
      req_entry_value = '0;
      req_random_choice = '0;
      req_random_wheel = '0;
      mismatch_count = 0;
      cycle_count = 0;
      sender_gap = 24;
      receiver_gap = 66;
      cur_city = 0;
      step_no = 0;
      ant_live = 1'b0;
      reg_cities = RESET_CITY_COUNT;
      reg_nbrs = RESET_NEIGHBOUR_COUNT;
      reg_threshold = '0;

      // directed plan, before the world is loaded: nothing here reads the tables
      plan.push_back(plan_req(OP_STEP, 7, 7, 32'h0, 0, 0));   // step with no ant placed
      plan.push_back(plan_place(1023, 1023));
      plan.push_back(plan_place(0, 0));
      d.kind = DIR_LOAD_WORLD;
      plan.push_back(d);
      // writes that land outside the tables in use
      plan.push_back(plan_req(OP_WRITE_NEIGHBOUR, 3, 32, 32'hFFFF_FFFF, 0, 0));
      plan.push_back(plan_req(OP_WRITE_NEIGHBOUR, 1023, 1023, 32'h0000_03FF, 0, 0));
      plan.push_back(plan_req(OP_WRITE_VALUE, 1023, 1023, 32'hFFFF_FFFF, 0, 0));
      // city count and list length below their floors
      plan.push_back(plan_csr(CSR_CITY_COUNT, 0));
      plan.push_back(plan_csr(CSR_NEIGHBOUR_COUNT, 0));
      plan.push_back(plan_place(5, 1));
      plan.push_back(plan_req(OP_STEP, 0, 0, 32'h0, 65535, 65535));
      plan.push_back(plan_req(OP_STEP, 0, 0, 32'h0, 0, 0));    // tour complete: silent
      // list length above its ceiling, greedy almost always
      plan.push_back(plan_csr(CSR_CITY_COUNT, WORLD_CITIES));
      plan.push_back(plan_csr(CSR_NEIGHBOUR_COUNT, 63));
      plan.push_back(plan_csr(CSR_BEST_THRESHOLD, 65535));
      plan.push_back(plan_place(1023, 1023 % WORLD_CITIES));
      plan.push_back(plan_req(OP_STEP, 0, 0, 32'h0, 0, 0));
      plan.push_back(plan_req(OP_STEP, 0, 0, 32'h0, 65535, 65535));
      plan.push_back(plan_req(OP_STEP, 0, 0, 32'h0, 65535, 0));
      plan.push_back(plan_csr(CSR_BEST_THRESHOLD, 1));
      plan.push_back(plan_req(OP_STEP, 0, 0, 32'h0, 0, 32768));
      plan.push_back(plan_req(OP_STEP, 0, 0, 32'h0, 1, 1));
      // city count above its ceiling: places only, a step would read unloaded rows
      plan.push_back(plan_csr(CSR_CITY_COUNT, 2047));
      plan.push_back(plan_place(1023, 1023));
      plan.push_back(plan_place(777, 777));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         case (plan[i].kind)
            DIR_REQUEST: issue_request(plan[i].req, plan[i].typed, plan[i].choice);
            DIR_CSR:     write_csr(plan[i].csr_idx, plan[i].csr_data);
            default:     load_world();
         endcase
      end

      // random phases: whole tours with random content plus some noise
      paused = 1'b0;
      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_CITY_COUNT, city_set[p]);
         write_csr(CSR_NEIGHBOUR_COUNT, nbr_set[p]);
         write_csr(CSR_BEST_THRESHOLD, thr_set[p]);
         case (p / 2)
            0: begin
               sender_gap = 24;
               receiver_gap = 66;
            end
            1: begin
               sender_gap = 66;
               receiver_gap = 24;
            end
            default: begin
               sender_gap = 0;
               receiver_gap = 0;
            end
         endcase
         issued = 0;
         while (issued < 120) begin
            send(random_request(OP_PLACE_ANT));
            issued++;
            // one step past the end of the tour as well
            for (int s = 0; s < live_cities(); s++) begin
               if ($urandom_range(99) < 15) begin
                  pick = $urandom_range(3);
                  q = random_request(opcode_type'(pick));
                  if (pick == OP_WRITE_VALUE && q.row < WORLD_CITIES && q.col < WORLD_CITIES &&
                      $urandom_range(1) == 0)
                     q.val = '0;
                  if (pick == OP_WRITE_NEIGHBOUR) q.col = $urandom_range(40);
                  send(q);
                  issued++;
               end
               send(random_request(OP_STEP));
               issued++;
               // hold the sender until the block has answered everything
               if (p == 2 && !paused && issued > 60) begin
                  paused = 1'b1;
                  req_valid <= 1'b0;
                  while (expected_choices.size() != 0) @(posedge clock);
                  @(negedge clock);
               end
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_choices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/ancs_pkg.sv
rtl/core/ant_next_city_selector.sv
verif/tb_ant_next_city_selector.sv
